// ----- design/fcc_pkg.sv -----
// Shared types and constants for the fan curve controller.
// No dependencies. Used by design/fan_curve_controller.sv.
`default_nettype none

package fcc_pkg;

  // curve geometry
  localparam int NUM_POINTS_DEF = 8;
  localparam int PT_W           = 8;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_TEMPS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_PERCENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERCENT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 3'd5;

  // curve mode codes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_STEPS  = 1'b1;

  // arithmetic constants
  localparam int MILLI_PER_DEG = 1000;
  localparam int DEG_LO        = 20;
  localparam int DEG_HI        = 100;
  localparam int PCT_MAX       = 100;
  localparam int MAX_PCT_RST   = 100;
  localparam int HOLD_RISE     = 25;
  localparam int HOLD_FALL     = 50;
  localparam int HYST_LINEAR   = 1000;
  localparam int HYST_STEPS    = 2000;

  typedef struct packed {
    logic signed [18:0] temp_milli;
    logic               force_req;
  } in_t;

  typedef struct packed {
    logic [6:0] curve_percent;
    logic       apply;
    logic [6:0] applied_percent;
  } out_t;

  // clamp an 8-bit percent to 100
  function automatic logic [6:0] sat_pct(input logic [7:0] v);
    logic [6:0] r;
    if (v > 8'(PCT_MAX)) begin
      r = 7'(PCT_MAX);
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/fan_curve_controller.sv -----
// Fan curve controller: bit-serial degree divide, serial segment search,
// shift-add interpolation and bit-serial restoring divide, then hysteresis.
// Depends on fcc_pkg.
//
//  channel | signals                               | dir | notes
//  --------+---------------------------------------+-----+------------------------
//  in      | in_valid_i, in_ready_o, in_data_i     | in  | one word at a time, only while idle
//  out     | out_valid_o, out_ready_i, out_data_o  | out | one word per in word
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i       | in  | write only, no wait
//
// A word is accepted, divided by 1000 and classified. A sample that falls below
// or above the curve limits goes straight to the finish step; otherwise the
// segment search walks the curve points, and on an interpolated segment the
// multiply and the segment divide run before the finish step. The output
// register lets a new word in while a result waits; a stalled output holds
// the finish step. Reset clears the hold counter, last temperature and percent.
`default_nettype none

module fan_curve_controller #(
  parameter int NUM_POINTS = fcc_pkg::NUM_POINTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire fcc_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output fcc_pkg::out_t                        out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fcc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fcc_pkg::*;

  localparam int IDX_W = $clog2(NUM_POINTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_QDIV  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  // control / config / state registers
  logic [2:0]              state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  logic [CFG_DATA_W-1:0]   point_temps_q, point_temps_d;
  logic [CFG_DATA_W-1:0]   point_pcts_q, point_pcts_d;
  logic                    mode_q, mode_d;
  logic [6:0]              min_pct_q, min_pct_d;
  logic [6:0]              max_pct_q, max_pct_d;
  logic                    enable_q, enable_d;
  logic [5:0]              hold_q, hold_d;
  logic signed [18:0]      last_temp_q, last_temp_d;
  logic [6:0]              last_pct_q, last_pct_d;

  // working registers
  logic signed [18:0]      temp_q, temp_d;
  logic                    force_q, force_d;
  logic                    neg_q, neg_d;
  logic [18:0]             mag_q, mag_d;
  logic [9:0]              rem_q, rem_d;
  logic [4:0]              cnt_q, cnt_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [PT_W-1:0]         prev_t_q, prev_t_d;
  logic [PT_W-1:0]         prev_p_q, prev_p_d;
  logic [PT_W-1:0]         dx_q, dx_d;
  logic [PT_W-1:0]         a_q, a_d;
  logic [PT_W-1:0]         b_q, b_d;
  logic [PT_W-1:0]         p0_q, p0_d;
  logic [PT_W-1:0]         p1_q, p1_d;
  logic [15:0]             acc_q, acc_d;
  logic [6:0]              pct_q, pct_d;
  out_t                    out_q, out_d;

  always_comb begin
    logic [10:0]       trial_div;
    logic              ge_div;
    logic [8:0]        trial_q;
    logic              ge_q;
    logic [8:0]        deg;
    logic [PT_W-1:0]   pt_t;
    logic [PT_W-1:0]   pt_p;
    logic [PT_W-1:0]   t_off;
    logic [15:0]       quot;
    logic signed [19:0] diff;
    logic [19:0]       adiff;
    logic [19:0]       hyst;
    logic [5:0]        hold_inc;
    logic [5:0]        need;
    logic              fire;

    state_d       = state_q;
    out_valid_d   = out_valid_q;
    point_temps_d = point_temps_q;
    point_pcts_d  = point_pcts_q;
    mode_d        = mode_q;
    min_pct_d     = min_pct_q;
    max_pct_d     = max_pct_q;
    enable_d      = enable_q;
    hold_d        = hold_q;
    last_temp_d   = last_temp_q;
    last_pct_d    = last_pct_q;
    temp_d        = temp_q;
    force_d       = force_q;
    neg_d         = neg_q;
    mag_d         = mag_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    prev_t_d      = prev_t_q;
    prev_p_d      = prev_p_q;
    dx_d          = dx_q;
    a_d           = a_q;
    b_d           = b_q;
    p0_d          = p0_q;
    p1_d          = p1_q;
    acc_d         = acc_q;
    pct_d         = pct_q;
    out_d         = out_q;

    // restoring divide step by 1000 on the sample magnitude
    trial_div = {rem_q, mag_q[18]};
    ge_div    = trial_div >= 11'(MILLI_PER_DEG);
    // restoring divide step by the segment width
    trial_q   = {rem_q[7:0], acc_q[15]};
    ge_q      = trial_q >= {1'b0, dx_q};
    quot      = {acc_q[14:0], ge_q};

    deg   = mag_q[8:0];
    pt_t  = point_temps_q[PT_W*idx_q +: PT_W];
    pt_p  = point_pcts_q[PT_W*idx_q +: PT_W];
    t_off = 8'(deg - {1'b0, prev_t_q});

    // hysteresis and hold decision
    diff     = 20'(signed'({temp_q[18], temp_q})) - 20'(signed'({last_temp_q[18], last_temp_q}));
    adiff    = diff[19] ? 20'(-diff) : 20'(diff);
    hyst     = (mode_q == MODE_STEPS) ? 20'(HYST_STEPS) : 20'(HYST_LINEAR);
    hold_inc = (hold_q >= 6'(HOLD_FALL)) ? 6'(HOLD_FALL) : 6'(hold_q + 6'd1);
    need     = (temp_q > last_temp_q) ? 6'(HOLD_RISE) : 6'(HOLD_FALL);
    fire     = enable_q && (force_q || ((hold_inc >= need) && (adiff >= hyst)));

    in_ready_o = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POINT_TEMPS:    point_temps_d = cfg_data_i;
        REG_POINT_PERCENTS: point_pcts_d  = cfg_data_i;
        REG_CURVE_MODE:     mode_d        = cfg_data_i[0];
        REG_MIN_PERCENT:    min_pct_d     = cfg_data_i[6:0];
        REG_MAX_PERCENT:    max_pct_d     = cfg_data_i[6:0];
        REG_ENABLE:         enable_d      = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          temp_d  = in_data_i.temp_milli;
          force_d = in_data_i.force_req;
          neg_d   = in_data_i.temp_milli[18];
          mag_d   = in_data_i.temp_milli[18] ? 19'(-in_data_i.temp_milli)
                                             : in_data_i.temp_milli;
          rem_d   = '0;
          cnt_d   = 5'd18;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = ge_div ? 10'(trial_div - 11'(MILLI_PER_DEG)) : trial_div[9:0];
        mag_d = {mag_q[17:0], ge_div};
        cnt_d = 5'(cnt_q - 5'd1);
        if (cnt_q == 5'd0) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        // negative samples truncate to zero or below: lower limit
        if (neg_q || deg < 9'(DEG_LO)) begin
          pct_d   = sat_pct({1'b0, min_pct_q});
          state_d = S_FIN;
        end else if (deg > 9'(DEG_HI)) begin
          pct_d   = sat_pct({1'b0, max_pct_q});
          state_d = S_FIN;
        end else begin
          idx_d   = '0;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (deg < {1'b0, pt_t}) begin
          if (idx_q == '0) begin
            pct_d   = sat_pct(pt_p);
            state_d = S_FIN;
          end else if (mode_q == MODE_STEPS) begin
            pct_d   = sat_pct(prev_p_q);
            state_d = S_FIN;
          end else begin
            // numerator = p0*(dx-t) + p1*t, never negative
            dx_d    = 8'(pt_t - prev_t_q);
            a_d     = t_off;
            b_d     = 8'(pt_t - prev_t_q - t_off);
            p0_d    = prev_p_q;
            p1_d    = pt_p;
            acc_d   = '0;
            cnt_d   = 5'd7;
            state_d = S_MUL;
          end
        end else begin
          prev_t_d = pt_t;
          prev_p_d = pt_p;
          if (idx_q == IDX_W'(NUM_POINTS - 1)) begin
            pct_d   = sat_pct(pt_p);
            state_d = S_FIN;
          end else begin
            idx_d = IDX_W'(idx_q + 1'b1);
          end
        end
      end
      S_MUL: begin
        acc_d = {acc_q[14:0], 1'b0}
              + (a_q[PT_W-1] ? {8'b0, p1_q} : 16'b0)
              + (b_q[PT_W-1] ? {8'b0, p0_q} : 16'b0);
        a_d   = {a_q[PT_W-2:0], 1'b0};
        b_d   = {b_q[PT_W-2:0], 1'b0};
        cnt_d = 5'(cnt_q - 5'd1);
        if (cnt_q == 5'd0) begin
          rem_d   = '0;
          cnt_d   = 5'd15;
          state_d = S_QDIV;
        end
      end
      S_QDIV: begin
        rem_d = ge_q ? {2'b0, 8'(trial_q - {1'b0, dx_q})} : {1'b0, trial_q};
        acc_d = quot;
        cnt_d = 5'(cnt_q - 5'd1);
        if (cnt_q == 5'd0) begin
          // quotient stays below 256
          pct_d   = sat_pct(quot[7:0]);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          if (enable_q) begin
            hold_d = fire ? 6'd0 : hold_inc;
          end
          if (fire) begin
            last_temp_d = temp_q;
            last_pct_d  = pct_q;
          end
          out_d.curve_percent   = pct_q;
          out_d.apply           = fire;
          out_d.applied_percent = fire ? pct_q : last_pct_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      point_temps_q <= '0;
      point_pcts_q  <= '0;
      mode_q        <= MODE_LINEAR;
      min_pct_q     <= '0;
      max_pct_q     <= 7'(MAX_PCT_RST);
      enable_q      <= 1'b0;
      hold_q        <= '0;
      last_temp_q   <= '0;
      last_pct_q    <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      point_temps_q <= point_temps_d;
      point_pcts_q  <= point_pcts_d;
      mode_q        <= mode_d;
      min_pct_q     <= min_pct_d;
      max_pct_q     <= max_pct_d;
      enable_q      <= enable_d;
      hold_q        <= hold_d;
      last_temp_q   <= last_temp_d;
      last_pct_q    <= last_pct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q   <= temp_d;
    force_q  <= force_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    idx_q    <= idx_d;
    prev_t_q <= prev_t_d;
    prev_p_q <= prev_p_d;
    dx_q     <= dx_d;
    a_q      <= a_d;
    b_q      <= b_d;
    p0_q     <= p0_d;
    p1_q     <= p1_d;
    acc_q    <= acc_d;
    pct_q    <= pct_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
